### design/spp_pkg.sv
// ----------------------------------------------------------------------------
// spp_pkg
// Types and codes shared by the streaming parallel port bus-cycle engine.
// ----------------------------------------------------------------------------
package spp_pkg;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_DWRITE = 2'd1,
    OP_AWRITE = 2'd2,
    OP_DREAD  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_ONE  = 3'b010,
    PH_TWO  = 3'b100
  } phase_t;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 4;

  localparam logic [CFG_INDEX_W-1:0] CFG_PORT_ENABLE   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_USB_OWNER     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_CLOCK_MODE    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_CS_ENABLE     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_CLOCK1_ENABLE = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_WAIT_STATES   = 3'd5;

  typedef struct packed {
    op_t        operation;
    logic [7:0] write_value;
    logic [7:0] port_in;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       busy_res;
    logic [3:0] address;
    logic [7:0] port_out;
    logic       port_drive;
    logic       oe_pin;
    logic       cs_pin;
    logic       clk1_pin;
    logic       clk2_pin;
    logic       interrupt;
  } result_t;

  typedef struct packed {
    logic                   en;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;
  } cfg_wr_t;

endpackage

### design/spp_engine.sv
// ----------------------------------------------------------------------------
// spp_engine
// Configuration registers and bus-cycle state; computes the next state and
// the result for the item being transferred out of the input register.
// ----------------------------------------------------------------------------
module spp_engine (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  spp_pkg::item_t   item,
  input  spp_pkg::cfg_wr_t cfg,
  output spp_pkg::result_t res
);

  // configuration
  logic       port_enable, port_enable_next;
  logic       usb_owner, usb_owner_next;
  logic [1:0] clock_mode, clock_mode_next;
  logic       cs_enable, cs_enable_next;
  logic       clk1_enable, clk1_enable_next;
  logic [3:0] wait_states, wait_states_next;

  // bus-cycle state
  spp_pkg::phase_t phase, phase_next;
  spp_pkg::op_t    access_kind, access_kind_next;
  logic [4:0]      wait_count, wait_count_next;
  logic [7:0]      data_latch, data_latch_next;
  logic [3:0]      address_nibble, address_nibble_next;
  logic            busy, busy_next;
  logic [7:0]      port_value, port_value_next;
  logic            port_direction, port_direction_next;
  logic            oe, oe_next;
  logic            cs, cs_next;
  logic            clk1, clk1_next;
  logic            clk2, clk2_next;

  logic [4:0]   wait_load;
  logic [4:0]   wait_dec;
  logic         start;
  spp_pkg::op_t start_kind;
  logic         start_drive;
  logic         start_oe;
  logic         sel_clk1;
  logic [7:0]   rd;
  logic         irq;

  assign wait_load = {1'b0, wait_states} + 5'd1;
  assign wait_dec  = (wait_count != 5'd0) ? wait_count - 5'd1 : wait_count;

  // which clock strobe fires at the end of phase one
  always_comb begin
    if (clock_mode[1]) begin
      sel_clk1 = address_nibble[0];
    end else if (clock_mode[0]) begin
      sel_clk1 = (access_kind != spp_pkg::OP_DREAD);
    end else begin
      sel_clk1 = (access_kind == spp_pkg::OP_AWRITE);
    end
  end

  always_comb begin
    port_enable_next    = port_enable;
    usb_owner_next      = usb_owner;
    clock_mode_next     = clock_mode;
    cs_enable_next      = cs_enable;
    clk1_enable_next    = clk1_enable;
    wait_states_next    = wait_states;
    phase_next          = phase;
    access_kind_next    = access_kind;
    wait_count_next     = wait_count;
    data_latch_next     = data_latch;
    address_nibble_next = address_nibble;
    busy_next           = busy;
    port_value_next     = port_value;
    port_direction_next = port_direction;
    oe_next             = oe;
    cs_next             = cs;
    clk1_next           = clk1;
    clk2_next           = clk2;
    start               = 1'b0;
    start_kind          = spp_pkg::OP_DWRITE;
    start_drive         = 1'b1;
    start_oe            = 1'b0;
    rd                  = 8'd0;
    irq                 = 1'b0;

    if (fire) begin
      unique case (item.operation)
        spp_pkg::OP_TICK: begin
          if (phase != spp_pkg::PH_IDLE) begin
            wait_count_next = wait_dec;
            if (wait_dec == 5'd0) begin
              if (phase == spp_pkg::PH_ONE) begin
                phase_next = spp_pkg::PH_TWO;
                if (access_kind == spp_pkg::OP_DREAD) begin
                  data_latch_next = item.port_in;
                end
                if (sel_clk1) begin
                  clk1_next = clk1 | clk1_enable;
                end else begin
                  clk2_next = 1'b1;
                end
                wait_count_next = wait_load;
              end else begin
                phase_next = spp_pkg::PH_IDLE;
                busy_next  = 1'b0;
                oe_next    = 1'b1;
                clk2_next  = 1'b0;
                if (cs_enable) begin
                  cs_next = 1'b0;
                end
                if (clk1_enable) begin
                  clk1_next = 1'b0;
                end
                irq = !usb_owner;
              end
            end
          end
        end
        spp_pkg::OP_DWRITE: begin
          if (port_enable) begin
            data_latch_next = item.write_value;
            port_value_next = item.write_value;
            start           = 1'b1;
            start_kind      = spp_pkg::OP_DWRITE;
          end
        end
        spp_pkg::OP_AWRITE: begin
          address_nibble_next = item.write_value[3:0];
          if (port_enable && (item.write_value[3:0] != address_nibble)) begin
            port_value_next = {4'd0, item.write_value[3:0]};
            start           = 1'b1;
            start_kind      = spp_pkg::OP_AWRITE;
          end
        end
        spp_pkg::OP_DREAD: begin
          if (port_enable) begin
            rd          = data_latch;
            start       = 1'b1;
            start_kind  = spp_pkg::OP_DREAD;
            start_drive = 1'b0;
            start_oe    = 1'b1;
          end
        end
      endcase

      // an access while busy simply restarts phase one
      if (start) begin
        port_direction_next = start_drive;
        busy_next           = 1'b1;
        phase_next          = spp_pkg::PH_ONE;
        access_kind_next    = start_kind;
        oe_next             = start_oe;
        if (cs_enable) begin
          cs_next = 1'b1;
        end
        wait_count_next = wait_load;
      end
    end else if (cfg.en) begin
      unique case (cfg.index)
        spp_pkg::CFG_PORT_ENABLE: begin
          // enabling parks the strobes but leaves busy alone
          if (cfg.data[0] && !port_enable) begin
            phase_next      = spp_pkg::PH_IDLE;
            wait_count_next = 5'd0;
            oe_next         = 1'b1;
            clk2_next       = 1'b0;
            if (clk1_enable) begin
              clk1_next = 1'b0;
            end
            if (cs_enable) begin
              cs_next = 1'b0;
            end
          end
          port_enable_next = cfg.data[0];
        end
        spp_pkg::CFG_USB_OWNER: begin
          usb_owner_next = cfg.data[0];
        end
        spp_pkg::CFG_CLOCK_MODE: begin
          clock_mode_next = cfg.data[1:0];
        end
        spp_pkg::CFG_CS_ENABLE: begin
          if (port_enable && cfg.data[0] && !cs_enable) begin
            cs_next = 1'b0;
          end
          cs_enable_next = cfg.data[0];
        end
        spp_pkg::CFG_CLOCK1_ENABLE: begin
          if (port_enable && cfg.data[0] && !clk1_enable) begin
            clk1_next = 1'b0;
          end
          clk1_enable_next = cfg.data[0];
        end
        spp_pkg::CFG_WAIT_STATES: begin
          wait_states_next = cfg.data;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      port_enable    <= 1'b0;
      usb_owner      <= 1'b0;
      clock_mode     <= 2'd0;
      cs_enable      <= 1'b0;
      clk1_enable    <= 1'b0;
      wait_states    <= 4'd0;
      phase          <= spp_pkg::PH_IDLE;
      access_kind    <= spp_pkg::OP_TICK;
      wait_count     <= 5'd0;
      data_latch     <= 8'd0;
      address_nibble <= 4'd0;
      busy           <= 1'b0;
      port_value     <= 8'd0;
      port_direction <= 1'b0;
      oe             <= 1'b1;
      cs             <= 1'b0;
      clk1           <= 1'b0;
      clk2           <= 1'b0;
    end else begin
      port_enable    <= port_enable_next;
      usb_owner      <= usb_owner_next;
      clock_mode     <= clock_mode_next;
      cs_enable      <= cs_enable_next;
      clk1_enable    <= clk1_enable_next;
      wait_states    <= wait_states_next;
      phase          <= phase_next;
      access_kind    <= access_kind_next;
      wait_count     <= wait_count_next;
      data_latch     <= data_latch_next;
      address_nibble <= address_nibble_next;
      busy           <= busy_next;
      port_value     <= port_value_next;
      port_direction <= port_direction_next;
      oe             <= oe_next;
      cs             <= cs_next;
      clk1           <= clk1_next;
      clk2           <= clk2_next;
    end
  end

  // result reflects the state after this item
  always_comb begin
    res.read_data  = rd;
    res.busy_res   = busy_next;
    res.address    = address_nibble_next;
    res.port_out   = port_value_next;
    res.port_drive = port_direction_next;
    res.oe_pin     = oe_next;
    res.cs_pin     = cs_enable_next & cs_next;
    res.clk1_pin   = clk1_enable_next & clk1_next;
    res.clk2_pin   = clk2_next;
    res.interrupt  = irq;
  end

`ifndef NO_ASSERTIONS
  a_active_busy : assert property (@(posedge clk) disable iff (rst)
    (phase != spp_pkg::PH_IDLE) |-> busy)
    else $error("bus cycle running without busy");

  a_active_count : assert property (@(posedge clk) disable iff (rst)
    (phase != spp_pkg::PH_IDLE) |-> (wait_count != 5'd0 && wait_count <= 5'd16))
    else $error("wait count out of range in an active phase");

  a_irq_ends : assert property (@(posedge clk) disable iff (rst)
    (fire && res.interrupt) |=> (phase == spp_pkg::PH_IDLE && !busy && oe))
    else $error("interrupt without cycle completion");

  a_read_input : assert property (@(posedge clk) disable iff (rst)
    (fire && item.operation == spp_pkg::OP_DREAD && port_enable)
      |=> (!port_direction && oe && phase == spp_pkg::PH_ONE))
    else $error("read did not start an input cycle");
`endif

endmodule

### design/streaming_parallel_port_cycle.sv
// ----------------------------------------------------------------------------
// streaming_parallel_port_cycle
// Parallel port bus-cycle engine with a streaming item interface.
// ----------------------------------------------------------------------------
// Usage:
//   item channel (item_valid / item_stall / item) carries ticks and port
//   accesses; every transfer yields exactly one transfer on the result
//   channel (result_valid / result_stall / result) with the pin levels and
//   status after that item.
//   Each item passes through the input register, then the result register,
//   where its result becomes valid. One item is taken every cycle while
//   item_stall is low; the state update for an item is a single pass of
//   logic between the input register and the result register.
//   When the receiver stalls, the result register holds and the input
//   register keeps accepting until it is full too, then item_stall rises
//   in the same cycle.
//   Configuration is written through cfg_write_en / cfg_index / cfg_data
//   while no items are in flight; indexes past the register list are ignored.
//   Reset (rst, synchronous) empties both registers, clears configuration,
//   and returns the port to idle with output enable high and other strobes
//   low.
// ----------------------------------------------------------------------------
module streaming_parallel_port_cycle (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  output logic                            item_stall,
  input  spp_pkg::item_t                  item,
  output logic                            result_valid,
  input  logic                            result_stall,
  output spp_pkg::result_t                result,
  input  logic                            cfg_write_en,
  input  logic [spp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [spp_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic             s1_valid;
  spp_pkg::item_t   s1_item;
  logic             advance;
  logic             fire;
  spp_pkg::cfg_wr_t cfg;
  spp_pkg::result_t eng_res;

  assign advance    = !result_valid || !result_stall;
  assign item_stall = s1_valid && !advance;
  assign fire       = s1_valid && advance;

  assign cfg.en    = cfg_write_en;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!item_stall) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      s1_item <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result <= eng_res;
    end
  end

  spp_engine u_engine (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .item (s1_item),
    .cfg  (cfg),
    .res  (eng_res)
  );

endmodule
